@@ rtl/core/kvc_pkg.sv @@
// Package for the keyboard velocity command block.
// Key codes, register indexes, reset values and shared types.
// No dependencies.
package kvc_pkg;

  // Register indexes on the configuration port
  localparam logic [2:0] RegLinFloor = 3'd0;
  localparam logic [2:0] RegLinCeil  = 3'd1;
  localparam logic [2:0] RegLinInc   = 3'd2;
  localparam logic [2:0] RegAngFloor = 3'd3;
  localparam logic [2:0] RegAngCeil  = 3'd4;
  localparam logic [2:0] RegAngInc   = 3'd5;

  // Register reset values, unsigned Q8.8
  localparam logic [15:0] RstLinFloor = 16'd51;   // 0.2 m/s
  localparam logic [15:0] RstLinCeil  = 16'd512;  // 2.0 m/s
  localparam logic [15:0] RstLinInc   = 16'd51;   // 0.2
  localparam logic [15:0] RstAngFloor = 16'd128;  // 0.5 rad/s
  localparam logic [15:0] RstAngCeil  = 16'd1024; // 4.0 rad/s
  localparam logic [15:0] RstAngInc   = 16'd51;   // 0.2

  // Request kinds and event classes
  localparam logic       KindKey  = 1'b0;
  localparam logic       KindTick = 1'b1;
  localparam logic [4:0] ClassKey = 5'd1;

  // Key actions
  localparam logic [1:0] ActRelease = 2'd0;
  localparam logic [1:0] ActPress   = 2'd1;

  // Key codes acted on
  localparam logic [9:0] CodeUp    = 10'd103;
  localparam logic [9:0] CodeDown  = 10'd108;
  localparam logic [9:0] CodeLeft  = 10'd105;
  localparam logic [9:0] CodeRight = 10'd106;
  localparam logic [9:0] CodeK1    = 10'd2;
  localparam logic [9:0] CodeK2    = 10'd3;
  localparam logic [9:0] CodeK3    = 10'd4;
  localparam logic [9:0] CodeK4    = 10'd5;
  localparam logic [9:0] CodeK9    = 10'd10;
  localparam logic [9:0] CodeK0    = 10'd11;

  // Configuration register contents
  typedef struct packed {
    logic [15:0] lin_floor;
    logic [15:0] lin_ceil;
    logic [15:0] lin_inc;
    logic [15:0] ang_floor;
    logic [15:0] ang_ceil;
    logic [15:0] ang_inc;
  } cfg_t;

  // Result of one request
  typedef struct packed {
    logic               has;
    logic signed [16:0] lin;
    logic signed [16:0] ang;
    logic               stop;
  } res_t;

endpackage

@@ rtl/core/keyboard_velocity_command.sv @@
// Keyboard velocity command: turns key events and timer ticks into linear and
// angular velocity commands in signed Q9.8. A request is registered on
// acceptance, decoded from the input register against the direction and scale
// state, and its result, if any, lands in the output register. One request is
// taken every cycle while results are taken as offered and no scale clamp is
// under way; a stalled result holds the decode stage, and the input register
// then takes a new request only while it is empty. The configuration port is
// always ready; the scales are clamped to the new registers in the cycle after
// a write to a valid index, and the decode stage holds for that cycle. Depends
// on kvc_pkg, kvc_cfg and kvc_core.
module keyboard_velocity_command (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               kind_i,
  input  logic [4:0]         event_class_i,
  input  logic [9:0]         key_code_i,
  input  logic [1:0]         key_action_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [16:0] linear_velocity_o,
  output logic signed [16:0] angular_velocity_o,
  output logic               stop_marker_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [2:0]         cfg_index_i,
  input  logic [15:0]        cfg_data_i
);
  import kvc_pkg::*;

  logic               in_vld_q, in_vld_d;
  logic               kind_q;
  logic [4:0]         cls_q;
  logic [9:0]         code_q;
  logic [1:0]         act_q;
  logic               out_vld_q, out_vld_d;
  logic signed [16:0] lin_q;
  logic signed [16:0] ang_q;
  logic               stop_q;
  logic               advance;
  logic               in_take;
  logic               out_load;
  logic               clamp;
  logic               send_en;
  cfg_t               cfg;
  res_t               res;

  // Handshake: the decode stage moves when the output register is free and
  // no scale clamp is under way
  assign advance     = in_vld_q && !clamp && (!out_vld_q || out_ready_i);
  assign in_ready_o  = !in_vld_q || advance;
  assign in_take     = in_valid_i && in_ready_o;
  assign out_load    = advance && res.has;
  assign cfg_ready_o = 1'b1;

  kvc_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (cfg_valid_i),
    .index_i (cfg_index_i),
    .data_i  (cfg_data_i),
    .cfg_o   (cfg),
    .clamp_o (clamp)
  );

  kvc_core u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .go_i          (advance),
    .kind_i        (kind_q),
    .event_class_i (cls_q),
    .key_code_i    (code_q),
    .key_action_i  (act_q),
    .cfg_i         (cfg),
    .clamp_i       (clamp),
    .res_o         (res),
    .send_en_o     (send_en)
  );

  // Valid flags of the two registers
  always_comb begin
    in_vld_d = in_vld_q;
    if (in_take) begin
      in_vld_d = 1'b1;
    end else if (advance) begin
      in_vld_d = 1'b0;
    end
    out_vld_d = out_vld_q;
    if (out_load) begin
      out_vld_d = 1'b1;
    end else if (out_ready_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  // Capture the request payload
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      kind_q <= kind_i;
      cls_q  <= event_class_i;
      code_q <= key_code_i;
      act_q  <= key_action_i;
    end
  end

  // Load the result payload
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      lin_q  <= res.lin;
      ang_q  <= res.ang;
      stop_q <= res.stop;
    end
  end

  assign out_valid_o        = out_vld_q;
  assign linear_velocity_o  = lin_q;
  assign angular_velocity_o = ang_q;
  assign stop_marker_o      = stop_q;

`ifndef SYNTHESIS
  // A stop result carries zero velocities
  a_stop_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load && res.stop |-> res.lin == 17'sd0 && res.ang == 17'sd0)
    else $error("stop result with non-zero velocity");

  // A velocity result is formed only while sending is enabled
  a_send_gate: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load && !res.stop |-> send_en)
    else $error("velocity result while sending disabled");

  // A result leaves the output register only when taken
  a_out_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(out_vld_q) |-> $past(out_ready_i))
    else $error("result dropped without being taken");

  // After a stop result is formed, sending is disabled
  a_stop_disables: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load && res.stop |=> !send_en)
    else $error("sending still enabled after stop");
`endif

endmodule

@@ rtl/core/kvc_cfg.sv @@
// Configuration registers of the keyboard velocity command block.
// Depends on kvc_pkg; flags a scale clamp in the cycle after each valid write.
module kvc_cfg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              wr_i,
  input  logic [2:0]        index_i,
  input  logic [15:0]       data_i,
  output kvc_pkg::cfg_t     cfg_o,
  output logic              clamp_o
);
  import kvc_pkg::*;

  cfg_t cfg_q, cfg_d;
  logic hit;
  logic clamp_q;

  // Decode the register index
  always_comb begin
    cfg_d = cfg_q;
    hit   = 1'b0;
    if (wr_i) begin
      unique case (index_i)
        RegLinFloor: begin cfg_d.lin_floor = data_i; hit = 1'b1; end
        RegLinCeil:  begin cfg_d.lin_ceil  = data_i; hit = 1'b1; end
        RegLinInc:   begin cfg_d.lin_inc   = data_i; hit = 1'b1; end
        RegAngFloor: begin cfg_d.ang_floor = data_i; hit = 1'b1; end
        RegAngCeil:  begin cfg_d.ang_ceil  = data_i; hit = 1'b1; end
        RegAngInc:   begin cfg_d.ang_inc   = data_i; hit = 1'b1; end
        default:     hit = 1'b0;
      endcase
    end
  end

  // Hold the registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.lin_floor <= RstLinFloor;
      cfg_q.lin_ceil  <= RstLinCeil;
      cfg_q.lin_inc   <= RstLinInc;
      cfg_q.ang_floor <= RstAngFloor;
      cfg_q.ang_ceil  <= RstAngCeil;
      cfg_q.ang_inc   <= RstAngInc;
      clamp_q         <= 1'b0;
    end else begin
      cfg_q   <= cfg_d;
      clamp_q <= hit;
    end
  end

  assign cfg_o   = cfg_q;
  assign clamp_o = clamp_q;

endmodule

@@ rtl/core/kvc_core.sv @@
// Direction, scale and enable state of the keyboard velocity command block.
// Depends on kvc_pkg; decodes one request a cycle while go_i is high and no clamp is under way, and forms its result.
module kvc_core (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          go_i,
  input  logic          kind_i,
  input  logic [4:0]    event_class_i,
  input  logic [9:0]    key_code_i,
  input  logic [1:0]    key_action_i,
  input  kvc_pkg::cfg_t cfg_i,
  input  logic          clamp_i,
  output kvc_pkg::res_t res_o,
  output logic          send_en_o
);
  import kvc_pkg::*;

  logic [1:0]  lin_dir_q, lin_dir_d;
  logic [1:0]  ang_dir_q, ang_dir_d;
  logic [15:0] lin_scale_q, lin_scale_d;
  logic [15:0] ang_scale_q, ang_scale_d;
  logic        send_en_q, send_en_d;
  logic        press;

  // Step a direction by one in the key's sense, held to -1..1
  function automatic logic [1:0] move_dir(logic [1:0] d, logic [1:0] act, logic pos);
    logic signed [2:0] s;
    s = $signed({d[1], d});
    if (act == ActPress) begin
      s = pos ? s + 3'sd1 : s - 3'sd1;
    end else if (act == ActRelease) begin
      s = pos ? s - 3'sd1 : s + 3'sd1;
    end
    if (s > 3'sd1) s = 3'sd1;
    if (s < -3'sd1) s = -3'sd1;
    return s[1:0];
  endfunction

  // Raise a scale, saturating at the ceiling
  function automatic logic [15:0] raise(logic [15:0] sc, logic [15:0] inc, logic [15:0] hi);
    logic [16:0] sum;
    sum = {1'b0, sc} + {1'b0, inc};
    return (sum < {1'b0, hi}) ? sum[15:0] : hi;
  endfunction

  // Lower a scale, saturating at the floor
  function automatic logic [15:0] lower(logic [15:0] sc, logic [15:0] inc, logic [15:0] lo);
    logic [16:0] dif;
    dif = {1'b0, sc} - {1'b0, inc};
    if (dif[16]) return lo;
    return (dif[15:0] > lo) ? dif[15:0] : lo;
  endfunction

  // Clamp a scale to its registers, floor first
  function automatic logic [15:0] clamp(logic [15:0] sc, logic [15:0] lo, logic [15:0] hi);
    if (sc < lo) return lo;
    if (sc > hi) return hi;
    return sc;
  endfunction

  // Direction times scale, signed Q9.8
  function automatic logic signed [16:0] vel(logic [1:0] d, logic [15:0] sc);
    logic [16:0] v;
    case (d)
      2'b01:   v = {1'b0, sc};
      2'b11:   v = ~{1'b0, sc} + 17'd1;
      default: v = '0;
    endcase
    return $signed(v);
  endfunction

  assign press = (key_action_i == ActPress);

  // Clamp the scales or decode the request, and form the next state and result
  always_comb begin
    lin_dir_d   = lin_dir_q;
    ang_dir_d   = ang_dir_q;
    lin_scale_d = lin_scale_q;
    ang_scale_d = ang_scale_q;
    send_en_d   = send_en_q;
    res_o       = '0;
    if (clamp_i) begin
      lin_scale_d = clamp(lin_scale_q, cfg_i.lin_floor, cfg_i.lin_ceil);
      ang_scale_d = clamp(ang_scale_q, cfg_i.ang_floor, cfg_i.ang_ceil);
    end else if (go_i) begin
      if (kind_i == KindTick) begin
        res_o.has = send_en_q;
        res_o.lin = vel(lin_dir_q, lin_scale_q);
        res_o.ang = vel(ang_dir_q, ang_scale_q);
      end else if (event_class_i == ClassKey) begin
        unique case (key_code_i)
          CodeUp:    lin_dir_d = move_dir(lin_dir_q, key_action_i, 1'b1);
          CodeDown:  lin_dir_d = move_dir(lin_dir_q, key_action_i, 1'b0);
          CodeLeft:  ang_dir_d = move_dir(ang_dir_q, key_action_i, 1'b1);
          CodeRight: ang_dir_d = move_dir(ang_dir_q, key_action_i, 1'b0);
          CodeK1: begin
            if (press) lin_scale_d = raise(lin_scale_q, cfg_i.lin_inc, cfg_i.lin_ceil);
          end
          CodeK2: begin
            if (press) lin_scale_d = lower(lin_scale_q, cfg_i.lin_inc, cfg_i.lin_floor);
          end
          CodeK3: begin
            if (press) ang_scale_d = raise(ang_scale_q, cfg_i.ang_inc, cfg_i.ang_ceil);
          end
          CodeK4: begin
            if (press) ang_scale_d = lower(ang_scale_q, cfg_i.ang_inc, cfg_i.ang_floor);
          end
          CodeK9: begin
            if (press) send_en_d = 1'b1;
          end
          CodeK0: begin
            if (press) begin
              send_en_d  = 1'b0;
              res_o.has  = 1'b1;
              res_o.stop = 1'b1;
            end
          end
          default: ;
        endcase
      end
    end
  end

  // Hold the state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lin_dir_q   <= 2'b00;
      ang_dir_q   <= 2'b00;
      lin_scale_q <= RstLinFloor;
      ang_scale_q <= RstAngFloor;
      send_en_q   <= 1'b1;
    end else begin
      lin_dir_q   <= lin_dir_d;
      ang_dir_q   <= ang_dir_d;
      lin_scale_q <= lin_scale_d;
      ang_scale_q <= ang_scale_d;
      send_en_q   <= send_en_d;
    end
  end

  assign send_en_o = send_en_q;

endmodule
